### sv/hcb_pkg.sv
// Shared types and constants for the Huffman code builder.
// Used by hcb_ctrl, hcb_datapath and huffman_code_builder; no dependencies.
package hcb_pkg;

   localparam int LABEL_W    = 8;
   localparam int WEIGHT_W   = 16;
   localparam int CODE_W     = 15;
   localparam int LEN_W      = 4;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 32;

   localparam logic [LEN_W-1:0] CODE_LEN_MAX = 4'd15;

   // datapath commands, one group per cycle from the controller
   typedef struct packed {
      logic load;        // store the accepted beat
      logic init;        // clear tree flags, first new node, first leaf
      logic scan_start;  // clear the two-minimum tracker
      logic scan_issue;  // read next node weight
      logic merge_a;     // write sum, first parent link, flags
      logic merge_b;     // write second parent link, next node
      logic walk_start;  // start walking from the current leaf
      logic walk_issue;  // read parent of current node, shift in a bit
      logic walk_take;   // move to the parent just read
      logic emit_done;   // result beat taken
   } hcb_cmd_type;

   typedef struct packed {
      logic close;       // accepted beat closes the set
      logic single;      // set holds one symbol
      logic scan_done;   // all nodes below the new one issued
      logic last_merge;  // the new node is the root
      logic cur_parent;  // walk node has a parent
      logic last_leaf;   // leaf being emitted is the final one
   } hcb_status_type;

endpackage

### sv/hcb_ctrl.sv
// Sequencer for the Huffman code builder: load, merge passes, code walk, emit.
// Depends on hcb_pkg for the command and status groups.
module hcb_ctrl
   import hcb_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   input  hcb_status_type status,
   output hcb_cmd_type    cmd
);

   typedef enum logic [8:0] {
      S_LOAD   = 9'b000000001,
      S_INIT   = 9'b000000010,
      S_SSTART = 9'b000000100,
      S_SCAN   = 9'b000001000,
      S_MERGEA = 9'b000010000,
      S_MERGEB = 9'b000100000,
      S_WSTART = 9'b001000000,
      S_WALK   = 9'b010000000,
      S_EMIT   = 9'b100000000
   } hcb_state_type;

   hcb_state_type state_ff, state_in;
   logic          walk_take_ff, walk_take_in;

   always_comb begin
      state_in     = state_ff;
      walk_take_in = 1'b0;
      cmd          = '0;
      req_tready   = 1'b0;
      rsp_tvalid   = 1'b0;
      unique case (state_ff)
         S_LOAD: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               if (status.close) state_in = S_INIT;
            end
         end
         S_INIT: begin
            cmd.init = 1'b1;
            state_in = status.single ? S_WSTART : S_SSTART;
         end
         S_SSTART: begin
            cmd.scan_start = 1'b1;
            state_in       = S_SCAN;
         end
         S_SCAN: begin
            // last weight read lands in the tracker on the same edge we leave
            if (status.scan_done) state_in = S_MERGEA;
            else cmd.scan_issue = 1'b1;
         end
         S_MERGEA: begin
            cmd.merge_a = 1'b1;
            state_in    = S_MERGEB;
         end
         S_MERGEB: begin
            cmd.merge_b = 1'b1;
            state_in    = status.last_merge ? S_WSTART : S_SSTART;
         end
         S_WSTART: begin
            cmd.walk_start = 1'b1;
            state_in       = S_WALK;
         end
         S_WALK: begin
            // per tree level: read the parent, then step to it
            if (walk_take_ff) begin
               cmd.walk_take = 1'b1;
            end else if (status.cur_parent) begin
               cmd.walk_issue = 1'b1;
               walk_take_in   = 1'b1;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               cmd.emit_done = 1'b1;
               state_in      = status.last_leaf ? S_LOAD : S_WSTART;
            end
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         walk_take_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         walk_take_ff <= walk_take_in;
      end
   end

endmodule

### sv/hcb_datapath.sv
// Datapath of the Huffman code builder: node and label memories, tree flags,
// two-minimum scan, merge and leaf-to-root walk. Depends on hcb_pkg.
module hcb_datapath
   import hcb_pkg::*;
#(
   parameter int MAX_SYMBOLS = 16
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  hcb_cmd_type           cmd,
   output hcb_status_type        status,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tlast,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

   localparam int CW     = $clog2(MAX_SYMBOLS + 1);
   localparam int NW     = $clog2(2 * MAX_SYMBOLS);
   localparam int NSLOTS = 1 << NW;
   localparam int LW     = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
   localparam int WW     = WEIGHT_W + $clog2(MAX_SYMBOLS);

   localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_SYMBOLS);

   // memories
   logic [WW-1:0]      weight_mem [NSLOTS];
   logic [NW-1:0]      parent_mem [NSLOTS];
   logic [LABEL_W-1:0] label_mem  [MAX_SYMBOLS];

   logic [WW-1:0]      weight_rd_ff;
   logic [NW-1:0]      parent_rd_ff;
   logic [LABEL_W-1:0] label_rd_ff;

   // control and working registers
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [CW-1:0]     n_ff, n_in;
   logic [NW-1:0]     new_ff, new_in;
   logic [NW-1:0]     scan_idx_ff, scan_idx_in;
   logic              pend_ff, pend_in;
   logic [NW-1:0]     pend_idx_ff, pend_idx_in;
   logic              a_ok_ff, a_ok_in, b_ok_ff, b_ok_in;
   logic [NW-1:0]     a_ff, a_in, b_ff, b_in;
   logic [WW-1:0]     wa_ff, wa_in, wb_ff, wb_in;
   logic [NSLOTS-1:0] has_par_ff, has_par_in;
   logic [NSLOTS-1:0] is_right_ff, is_right_in;
   logic [CW-1:0]     leaf_ff, leaf_in;
   logic [NW-1:0]     cur_ff, cur_in;
   logic [CODE_W-1:0] code_ff, code_in;
   logic [LEN_W-1:0]  len_ff, len_in;

   logic [LABEL_W-1:0]  req_label;
   logic [WEIGHT_W-1:0] req_weight;
   logic [CW-1:0]       load_count;
   logic                cand;
   logic [NW-1:0]       m_idx;

   assign req_label  = req_tdata[LABEL_W-1:0];
   assign req_weight = req_tdata[LABEL_W +: WEIGHT_W];
   assign load_count = cnt_ff + 1'b1;
   assign m_idx      = NW'({n_ff, 1'b0} - 1'b1);
   assign cand       = pend_ff && !has_par_ff[pend_idx_ff];

   always_comb begin
      status.close      = req_tlast || (load_count == MAX_COUNT);
      status.single     = (n_ff == CW'(1));
      status.scan_done  = (scan_idx_ff == new_ff);
      status.last_merge = (new_ff == m_idx);
      status.cur_parent = has_par_ff[cur_ff];
      status.last_leaf  = (leaf_ff == n_ff);
   end

   always_comb begin
      cnt_in      = cnt_ff;
      n_in        = n_ff;
      new_in      = new_ff;
      scan_idx_in = scan_idx_ff;
      pend_in     = cmd.scan_issue;
      pend_idx_in = scan_idx_ff;
      a_ok_in     = a_ok_ff;
      b_ok_in     = b_ok_ff;
      a_in        = a_ff;
      b_in        = b_ff;
      wa_in       = wa_ff;
      wb_in       = wb_ff;
      has_par_in  = has_par_ff;
      is_right_in = is_right_ff;
      leaf_in     = leaf_ff;
      cur_in      = cur_ff;
      code_in     = code_ff;
      len_in      = len_ff;

      if (cmd.load) begin
         if (status.close) begin
            n_in   = load_count;
            cnt_in = '0;
         end else begin
            cnt_in = load_count;
         end
      end
      if (cmd.init) begin
         has_par_in  = '0;
         is_right_in = '0;
         new_in      = NW'(n_ff) + 1'b1;
         leaf_in     = CW'(1);
      end
      if (cmd.scan_start) begin
         scan_idx_in = NW'(1);
         a_ok_in     = 1'b0;
         b_ok_in     = 1'b0;
      end
      if (cmd.scan_issue) scan_idx_in = scan_idx_ff + 1'b1;

      // keep the lowest-index minimum and the lowest-index minimum of the rest
      if (cand) begin
         priority if (!a_ok_ff) begin
            a_ok_in = 1'b1;
            a_in    = pend_idx_ff;
            wa_in   = weight_rd_ff;
         end else if (weight_rd_ff < wa_ff) begin
            b_ok_in = 1'b1;
            b_in    = a_ff;
            wb_in   = wa_ff;
            a_in    = pend_idx_ff;
            wa_in   = weight_rd_ff;
         end else if (!b_ok_ff || weight_rd_ff < wb_ff) begin
            b_ok_in = 1'b1;
            b_in    = pend_idx_ff;
            wb_in   = weight_rd_ff;
         end
      end

      if (cmd.merge_a) begin
         has_par_in[a_ff]  = 1'b1;
         has_par_in[b_ff]  = 1'b1;
         is_right_in[b_ff] = 1'b1;
      end
      if (cmd.merge_b) new_in = new_ff + 1'b1;

      if (cmd.walk_start) begin
         cur_in  = NW'(leaf_ff);
         code_in = '0;
         len_in  = '0;
      end
      if (cmd.walk_issue) begin
         if (len_ff < CODE_LEN_MAX) begin
            code_in[len_ff] = is_right_ff[cur_ff];
            len_in          = len_ff + 1'b1;
         end
      end
      if (cmd.walk_take) cur_in = parent_rd_ff;
      if (cmd.emit_done) leaf_in = leaf_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff      <= '0;
         n_ff        <= '0;
         pend_ff     <= 1'b0;
         a_ok_ff     <= 1'b0;
         b_ok_ff     <= 1'b0;
         has_par_ff  <= '0;
         is_right_ff <= '0;
         new_ff      <= '0;
         scan_idx_ff <= '0;
         leaf_ff     <= '0;
         cur_ff      <= '0;
      end else begin
         cnt_ff      <= cnt_in;
         n_ff        <= n_in;
         pend_ff     <= pend_in;
         a_ok_ff     <= a_ok_in;
         b_ok_ff     <= b_ok_in;
         has_par_ff  <= has_par_in;
         is_right_ff <= is_right_in;
         new_ff      <= new_in;
         scan_idx_ff <= scan_idx_in;
         leaf_ff     <= leaf_in;
         cur_ff      <= cur_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_idx_ff <= pend_idx_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      wa_ff       <= wa_in;
      wb_ff       <= wb_in;
      code_ff     <= code_in;
      len_ff      <= len_in;
   end

   // node weights: leaves at load, sums at merge; scan reads
   always_ff @(posedge clock) begin
      if (cmd.load)
         weight_mem[NW'(load_count)] <= WW'(req_weight);
      else if (cmd.merge_a)
         weight_mem[new_ff] <= wa_ff + wb_ff;
      if (cmd.scan_issue)
         weight_rd_ff <= weight_mem[scan_idx_ff];
   end

   // parent links, one per cycle over the two merge states
   always_ff @(posedge clock) begin
      if (cmd.merge_a)
         parent_mem[a_ff] <= new_ff;
      else if (cmd.merge_b)
         parent_mem[b_ff] <= new_ff;
      if (cmd.walk_issue)
         parent_rd_ff <= parent_mem[cur_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.load)
         label_mem[LW'(cnt_ff)] <= req_label;
      if (cmd.walk_start)
         label_rd_ff <= label_mem[LW'(leaf_ff - 1'b1)];
   end

   assign rsp_tdata = {{(RSP_DATA_W - LABEL_W - CODE_W - LEN_W){1'b0}},
                       len_ff, code_ff, label_rd_ff};
   assign rsp_tlast = status.last_leaf;

endmodule

### sv/huffman_code_builder.sv
// Top level of the Huffman code builder: controller plus datapath.
// Depends on hcb_pkg, hcb_ctrl and hcb_datapath.
//
//   channel  direction  tdata (low bit up)                      tlast
//   req_     in         symbol_label[7:0], weight[23:8]         last_symbol
//   rsp_     out        label_out[7:0], code_bits[22:8],        last_code
//                       code_length[26:23], zero[31:27]
//
// A load beat is taken every cycle while the set is open. The closing beat (tlast,
// or the one that fills MAX_SYMBOLS) starts the build: each of the n-1 merges scans
// nodes 1..k through the single weight memory read port. Each code is then built by
// a leaf-to-root walk through the parent memory, reading the parent and then stepping
// to it at each tree level, and is held as the emit beat. req_tready is low from the
// closing beat until the last code beat is taken; rsp_ stalls simply hold the beat.
// Synchronous reset returns to the open-set state with no symbols loaded.
module huffman_code_builder
   import hcb_pkg::*;
#(
   parameter int MAX_SYMBOLS = 16
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // symbol_label, weight
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // label_out, code_bits, code_length, pad
   output logic                  rsp_tlast
);

   hcb_cmd_type    cmd;
   hcb_status_type status;

   hcb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   hcb_datapath #(
      .MAX_SYMBOLS (MAX_SYMBOLS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

endmodule

### tb/huffman_code_builder_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for huffman_code_builder: a directed table, then random symbol sets.
// Results are checked against an in-bench tree builder and code walker; needs hcb_pkg and the RTL.
module huffman_code_builder_tb
   import hcb_pkg::*;
();

   localparam int SET_MAX      = 16;
   localparam int NODE_MAX     = 2 * SET_MAX - 1;
   localparam int RANDOM_LOADS = 445;
   localparam int LIMIT_CYCLES = 400000;
   localparam int DRAIN_CYCLES = 1200;

   typedef struct packed {
      logic [LABEL_W-1:0] label;
      logic [CODE_W-1:0]  bits;
      logic [LEN_W-1:0]   len;
      logic               last;
   } code_beat_type;

   // code typed into the table, used instead of the computed one when chk is set
   typedef struct packed {
      logic              chk;
      logic [CODE_W-1:0] bits;
      logic [LEN_W-1:0]  len;
   } code_hint_type;

   typedef struct packed {
      logic [LABEL_W-1:0]  label;
      logic [WEIGHT_W-1:0] weight;
      logic                last;
      code_hint_type       hint;
   } load_row_type;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tlast  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   // predictor state
   logic [LABEL_W-1:0] sym_label [1:SET_MAX];
   code_hint_type      sym_hint  [1:SET_MAX];
   logic [19:0]        tree_wt   [1:NODE_MAX];
   logic [4:0]         tree_up   [1:NODE_MAX];
   logic [4:0]         tree_left [1:NODE_MAX];
   int                 fill = 0;

   code_beat_type pending_codes [$];
   code_hint_type load_hints [$];
   load_row_type  dir_rows [$];
   code_hint_type accepted_hint;
   code_beat_type want;

   int mismatches   = 0;
   int cycles       = 0;
   int req_idle_pct = 8;
   int rsp_idle_pct = 81;

   huffman_code_builder #(.MAX_SYMBOLS(SET_MAX)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // lowest parentless node in 1..k with the least weight, other than skip
   function automatic int lightest(input int k, input int skip);
      int best;
      best = 0;
      for (int i = 1; i <= k; i++) begin
         if (tree_up[i] != 0 || i == skip) continue;
         if (best == 0 || tree_wt[i] < tree_wt[best]) best = i;
      end
      return best;
   endfunction

   task automatic huffman_predict(input logic [LABEL_W-1:0] label,
                                  input logic [WEIGHT_W-1:0] weight,
                                  input logic last, input code_hint_type hint);
      int n, a, b, c, f, len;
      logic [CODE_W-1:0] bits;
      code_beat_type beat;
      if (fill >= SET_MAX) fill = 0;
      fill++;
      sym_label[fill] = label;
      sym_hint[fill]  = hint;
      tree_wt[fill]   = {4'b0, weight};
      if (!(last || fill >= SET_MAX)) return;
      n = fill;
      for (int i = 1; i <= 2 * n - 1; i++) begin
         tree_up[i]   = '0;
         tree_left[i] = '0;
      end
      for (int k = n + 1; k <= 2 * n - 1; k++) begin
         a = lightest(k - 1, 0);
         b = lightest(k - 1, a);
         tree_up[a]   = 5'(k);
         tree_up[b]   = 5'(k);
         tree_left[k] = 5'(a);
         tree_wt[k]   = tree_wt[a] + tree_wt[b];
      end
      // leaf-to-root walk: first step lands in bit 0, the root-side bit ends up on top
      for (int i = 1; i <= n; i++) begin
         bits = '0;
         len  = 0;
         c    = i;
         f    = tree_up[i];
         while (f != 0) begin
            if (tree_left[f] != c && len < 15) bits[len] = 1'b1;
            len++;
            c = f;
            f = tree_up[f];
         end
         if (len > 15) len = 15;
         beat.label = sym_label[i];
         beat.bits  = sym_hint[i].chk ? sym_hint[i].bits : bits;
         beat.len   = sym_hint[i].chk ? sym_hint[i].len : LEN_W'(len);
         beat.last  = (i == n);
         pending_codes.push_back(beat);
      end
      fill = 0;
   endtask

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         accepted_hint = (load_hints.size() != 0) ? load_hints.pop_front() : '0;
         huffman_predict(req_tdata[7:0], req_tdata[23:8], req_tlast, accepted_hint);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_codes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected code beat: tdata %h tlast %b", rsp_tdata, rsp_tlast);
         end else begin
            want = pending_codes.pop_front();
            if (rsp_tdata[7:0] !== want.label || rsp_tdata[22:8] !== want.bits ||
                rsp_tdata[26:23] !== want.len || rsp_tdata[31:27] !== 5'b0 ||
                rsp_tlast !== want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("code mismatch: label %h/%h bits %h/%h len %0d/%0d last %b/%b pad %h",
                           want.label, rsp_tdata[7:0], want.bits, rsp_tdata[22:8],
                           want.len, rsp_tdata[26:23], want.last, rsp_tlast,
                           rsp_tdata[31:27]);
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   function automatic void add_row(input logic [LABEL_W-1:0] label,
                                   input logic [WEIGHT_W-1:0] weight, input logic last,
                                   input logic chk, input logic [CODE_W-1:0] bits,
                                   input logic [LEN_W-1:0] len);
      load_row_type row;
      row.label  = label;
      row.weight = weight;
      row.last   = last;
      row.hint   = {chk, bits, len};
      dir_rows.push_back(row);
   endfunction

   task automatic send_load(input logic [LABEL_W-1:0] label, input logic [WEIGHT_W-1:0] weight,
                            input logic last, input code_hint_type hint);
      load_hints.push_back(hint);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {weight, label};
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_codes.size() != 0) @(posedge clock);
   endtask

   initial begin
      int sent, n, style, phase, cur_phase;
      logic [WEIGHT_W-1:0] w, common;
      logic lst;

      // single-symbol sets: no merge, empty code
      add_row(8'h00, 16'h0000, 1'b1, 1'b1, 15'd0, 4'd0);
      add_row(8'hFF, 16'hFFFF, 1'b1, 1'b1, 15'd0, 4'd0);
      // two symbols, lighter one second: it becomes the left child
      add_row(8'hA5, 16'hFFFF, 1'b0, 1'b1, 15'd1, 4'd1);
      add_row(8'h5A, 16'h0000, 1'b1, 1'b1, 15'd0, 4'd1);
      // two equal weights: tie goes to the lower index on the left
      add_row(8'h01, 16'h0007, 1'b0, 1'b1, 15'd0, 4'd1);
      add_row(8'h02, 16'h0007, 1'b1, 1'b1, 15'd1, 4'd1);
      add_row(8'h10, 16'h0001, 1'b0, 1'b0, '0, '0);
      add_row(8'h20, 16'h0002, 1'b0, 1'b0, '0, '0);
      add_row(8'h30, 16'h0004, 1'b1, 1'b0, '0, '0);
      // full set of zero weights, no tlast: capacity closes it, balanced tree
      for (int i = 0; i < SET_MAX; i++)
         add_row(8'h40 + 8'(i), 16'h0000, 1'b0, 1'b1, 15'(i), 4'd4);

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      do @(posedge clock); while (reset);

      foreach (dir_rows[i])
         send_load(dir_rows[i].label, dir_rows[i].weight, dir_rows[i].last, dir_rows[i].hint);
      wait_drained();

      sent      = 0;
      cur_phase = 0;
      while (sent < RANDOM_LOADS) begin
         phase = (sent < RANDOM_LOADS / 3) ? 0 : (sent < 2 * RANDOM_LOADS / 3) ? 1 : 2;
         if (phase != cur_phase) begin
            wait_drained();
            req_idle_pct = (phase == 1) ? 81 : 0;
            rsp_idle_pct = (phase == 1) ? 8 : 0;
            cur_phase    = phase;
         end
         style  = $urandom_range(0, 9);
         n      = (style == 9) ? SET_MAX : $urandom_range(1, SET_MAX);
         common = $urandom_range(0, 65535);
         for (int j = 0; j < n; j++) begin
            unique case (style)
               4, 5:    w = $urandom_range(0, 3);
               6:       w = common;
               7:       w = (j == 0) ? 16'd1 : 16'd1 << (j - 1);  // deepest tree
               8:       w = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
               9:       w = $urandom_range(0, 255);
               default: w = $urandom_range(0, 65535);
            endcase
            if (j != n - 1) lst = 1'b0;
            else if (n == SET_MAX) lst = 1'($urandom_range(0, 1));
            else lst = 1'b1;
            send_load(8'($urandom_range(0, 255)), w, lst, '0);
            sent++;
         end
      end
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && pending_codes.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

### huffman_code_builder.f
sv/hcb_pkg.sv
sv/hcb_ctrl.sv
sv/hcb_datapath.sv
sv/huffman_code_builder.sv
tb/huffman_code_builder_tb.sv
